>>> rtl/krct_pkg.sv
// ----------------------------------------------------------------------------
// krct_pkg
// shared types and constants of the keyed reference count table
// ----------------------------------------------------------------------------
package krct_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned KEY_BITS      = 64;
  localparam int unsigned KEY_IN_W      = 64;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_GET        = 3'd2,
    CMD_DELETE     = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [COUNT_W-1:0]  count;
  } ent_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] ra;
    logic             we;
    logic [IDX_W-1:0] wa;
    ent_t             wdata;
  } mem_req_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [KEY_IN_W-1:0] partition_key;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic                removed;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

>>> rtl/krct_if.sv
// ----------------------------------------------------------------------------
// krct_if
// valid/ready channels for commands and responses
// ----------------------------------------------------------------------------
interface krct_cmd_if
  import krct_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [KEY_IN_W-1:0] partition_key;

  modport source (output valid, output command, output partition_key, input ready);
  modport sink   (input valid, input command, input partition_key, output ready);
endinterface

interface krct_rsp_if
  import krct_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  count;
  logic                removed;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output count, output removed, output status, input ready);
  modport sink   (input valid, input count, input removed, input status, output ready);
endinterface

>>> rtl/krct_mem.sv
// ----------------------------------------------------------------------------
// krct_mem
// key and count storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module krct_mem
  import krct_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output ent_t     rdata_o
);

  ent_t mem_q [TABLE_ENTRIES];
  ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.wa] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.ra];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/krct_ctrl.sv
// ----------------------------------------------------------------------------
// krct_ctrl
// command sequencer: scans the table, then does the read-modify-write
// ----------------------------------------------------------------------------
module krct_ctrl
  import krct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  cmd_t     cmd_i,
  output logic     cmd_ready_o,
  input  logic     rsp_stall_i,
  output logic     rsp_push_o,
  output rsp_t     rsp_o,
  output mem_req_t mem_req_o,
  input  ent_t     mem_rdata_i
);

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     rd_vld_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic [CMD_W-1:0]         cmd_q;
  logic [KEY_BITS-1:0]      key_q;
  logic                     hit_q, free_q, any_q;
  logic [IDX_W-1:0]         hit_idx_q, free_idx_q;
  logic [COUNT_W-1:0]       hit_cnt_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic                     exec_fire;
  logic                     vset, vclr, vclr_all;
  logic [IDX_W-1:0]         vidx;
  logic                     rd_valid_ent;
  logic [COUNT_W-1:0]       cnt_inc;

  assign exec_fire    = (state_q == S_EXEC) && !rsp_stall_i;
  assign cmd_ready_o  = (state_q == S_IDLE);
  assign rsp_push_o   = exec_fire;
  assign rd_valid_ent = valid_q[rd_idx_q];
  assign cnt_inc      = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + COUNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_valid_i) state_d = S_SCAN;
      S_SCAN: if (idx_q == IDX_LAST) state_d = S_LAST;
      S_LAST: state_d = S_EXEC;
      S_EXEC: if (!rsp_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory access and result
  always_comb begin
    mem_req_o          = '0;
    mem_req_o.re       = (state_q == S_SCAN);
    mem_req_o.ra       = idx_q;
    mem_req_o.wdata.key = key_q;
    idx_d              = (state_q == S_SCAN) ? idx_q + IDX_W'(1) : '0;
    rsp_o              = '0;
    rsp_o.status       = ST_OK;
    vset               = 1'b0;
    vclr               = 1'b0;
    vclr_all           = 1'b0;
    vidx               = hit_idx_q;
    unique case (cmd_q)
      CMD_REGISTER: begin
        if (hit_q) begin
          mem_req_o.we          = exec_fire;
          mem_req_o.wa          = hit_idx_q;
          mem_req_o.wdata.count = cnt_inc;
          rsp_o.count           = cnt_inc;
        end else if (free_q) begin
          mem_req_o.we          = exec_fire;
          mem_req_o.wa          = free_idx_q;
          mem_req_o.wdata.count = '0;
          vset                  = 1'b1;
          vidx                  = free_idx_q;
        end else begin
          rsp_o.status = ST_FULL;
        end
      end
      CMD_UNREGISTER: begin
        if (!hit_q) begin
          rsp_o.status = ST_NOT_FOUND;
        end else if (hit_cnt_q == '0) begin
          vclr          = 1'b1;
          rsp_o.removed = 1'b1;
        end else begin
          mem_req_o.we          = exec_fire;
          mem_req_o.wa          = hit_idx_q;
          mem_req_o.wdata.count = hit_cnt_q - COUNT_W'(1);
          rsp_o.count           = hit_cnt_q - COUNT_W'(1);
        end
      end
      CMD_GET: begin
        if (hit_q) begin
          rsp_o.count = hit_cnt_q;
        end else begin
          rsp_o.status = ST_NOT_FOUND;
        end
      end
      CMD_DELETE: begin
        if (hit_q) begin
          vclr          = 1'b1;
          rsp_o.removed = 1'b1;
        end
      end
      CMD_CLEAR: begin
        vclr_all      = 1'b1;
        rsp_o.removed = any_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      any_q    <= 1'b0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= (state_q == S_SCAN);
      if (state_q == S_IDLE) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        any_q  <= 1'b0;
      end else if (rd_vld_q) begin
        if (rd_valid_ent && mem_rdata_i.key == key_q) hit_q <= 1'b1;
        if (!rd_valid_ent) free_q <= 1'b1;
        if (rd_valid_ent) any_q <= 1'b1;
      end
      if (exec_fire) begin
        if (vclr_all) begin
          valid_q <= '0;
        end else if (vset) begin
          valid_q[vidx] <= 1'b1;
        end else if (vclr) begin
          valid_q[vidx] <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_q <= cmd_i.command;
      key_q <= cmd_i.partition_key[KEY_BITS-1:0];
    end
    if (rd_vld_q && !hit_q && rd_valid_ent && mem_rdata_i.key == key_q) begin
      hit_idx_q <= rd_idx_q;
      hit_cnt_q <= mem_rdata_i.count;
    end
    if (rd_vld_q && !free_q && !rd_valid_ent) begin
      free_idx_q <= rd_idx_q;
    end
  end

`ifndef SYNTHESIS
  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN || state_q == S_LAST))
    else $error("read data outside scan");

  a_wr_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == S_EXEC && !rsp_stall_i))
    else $error("memory write outside execute");

  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && hit_q) |-> valid_q[hit_idx_q])
    else $error("matched entry not valid");

  a_free_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && free_q) |-> !valid_q[free_idx_q])
    else $error("free entry is valid");

  a_exec_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> (state_q == S_IDLE))
    else $error("execute did not return to idle");
`endif

endmodule

>>> rtl/keyed_reference_count_table.sv
// ----------------------------------------------------------------------------
// keyed_reference_count_table
// table of partition keys with registration counts
// ----------------------------------------------------------------------------
// Commands enter on cmd_i (command, partition_key) and each gives exactly one
// response on rsp_o (count, removed, status); both are valid/ready channels
// and an item moves on a transfer, valid and ready high at a rising edge.
// Every command scans all TABLE_ENTRIES slots through the single read port
// of the key/count memory, one slot a cycle, then goes through S_LAST to an
// execute step that does any write back. The response is pushed into the
// output register in that execute step, and no new command is taken until
// the sequencer is back in idle, so the full scan sets the command rate.
// cmd_i.ready is high only while the sequencer is idle; a response waiting
// in the output register does not block the next command, but the execute
// cycle of that command holds until the output register is free.
// Reset empties the table at once (valid flags cleared); keys and counts in
// the memory are only used after they are written, so no clearing pass runs.
// ----------------------------------------------------------------------------
module keyed_reference_count_table
  import krct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  krct_cmd_if.sink   cmd_i,
  krct_rsp_if.source rsp_o
);

  cmd_t     cmd;
  rsp_t     rsp;
  rsp_t     rsp_q;
  logic     rsp_valid_q;
  logic     rsp_stall;
  logic     rsp_push;
  logic     cmd_ready;
  mem_req_t mem_req;
  ent_t     mem_rdata;

  assign cmd.command       = cmd_i.command;
  assign cmd.partition_key = cmd_i.partition_key;
  assign cmd_i.ready       = cmd_ready;
  assign rsp_stall         = rsp_valid_q && !rsp_o.ready;

  krct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .rsp_stall_i (rsp_stall),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  krct_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_push) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_push) begin
      rsp_q <= rsp;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.count   = rsp_q.count;
  assign rsp_o.removed = rsp_q.removed;
  assign rsp_o.status  = rsp_q.status;

endmodule
